// ===== src/bpp_pkg.sv =====
// ============================================================================
// bpp_pkg
// Shared types, constants and helpers for the bitfield pixel premultiply core.
// ============================================================================
package bpp_pkg;

    // Register map, word index (byte address / 4)
    typedef enum logic [1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2,
        REG_ALPHA_MASK = 2'd3
    } t_reg_idx;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [31:0] ALPHA_MASK_RST = 32'hFF00_0000;

    // floor(x / 255) for x < 2^26 as (x * RECIP_255) >> RECIP_SHIFT
    localparam int unsigned X_W         = 26;
    localparam int unsigned RECIP_W     = 27;
    localparam int unsigned RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP_255 = 27'd67372037;
    localparam int unsigned Q_W         = 18;

    // Digit-by-digit square root state
    localparam int unsigned ROOT_W = 9;
    localparam int unsigned REM_W  = 10;

    typedef struct packed {
        logic [Q_W-1:0]    q;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    // Position of the lowest set bit; zero mask gives 0
    function automatic logic [4:0] low_bit_index(input logic [31:0] m);
        logic [31:0] oh;
        logic [4:0]  idx;
        oh  = m & (~m + 32'd1);
        idx = '0;
        for (int b = 0; b < 5; b++) begin
            for (int i = 0; i < 32; i++) begin
                if (((i >> b) & 1) == 1) begin
                    idx[b] = idx[b] | oh[i];
                end
            end
        end
        return idx;
    endfunction

    // One restoring square root step, consuming the bit pair at index pair_idx
    function automatic t_sqrt sqrt_step(input t_sqrt st, input int unsigned pair_idx);
        t_sqrt             nx;
        logic [REM_W+1:0]  acc;
        logic [REM_W+1:0]  trial;
        nx    = st;
        acc   = {st.rem, st.q[2*pair_idx +: 2]};
        trial = {1'b0, st.root, 2'b01};
        if (acc >= trial) begin
            nx.rem  = REM_W'(acc - trial);
            nx.root = {st.root[ROOT_W-2:0], 1'b1};
        end else begin
            nx.rem  = REM_W'(acc);
            nx.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

// ===== src/bitfield_pixel_premultiply_core.sv =====
// ============================================================================
// bitfield_pixel_premultiply_core
// Bitfield pixel to premultiplied ARGB8888, ten-stage pipeline.
// ============================================================================
// Input channel: i_valid / o_ready carry one 32-bit source word; output
// channel: o_valid / i_ready carry one ARGB word (alpha, red, green, blue).
// Four channel masks sit on an APB-style port at byte addresses 0, 4, 8, 12
// (red, green, blue, alpha); pready is tied high and reads return the mask.
// A zero alpha mask selects the bits not covered by the three colour masks.
// Throughput is one word per clock while the receiver accepts. The stages
// are: input register, mask, shift and clamp, c*c, c*c*a, divide by 255
// through a reciprocal multiply, three square root stages of three result
// bits each, and the rounding stage that feeds the output register.
// Every stage has its own valid bit and advances when empty or when the next
// stage advances, so bubbles collapse and a stalled receiver only backs the
// pipe up once it is full; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipe and restores the default
// masks (0x00FF0000, 0x0000FF00, 0x000000FF, 0xFF000000).
// ============================================================================
module bitfield_pixel_premultiply_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB-style configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpp_pkg::ADDR_W-1:0]    paddr,
    input  logic [bpp_pkg::DATA_W-1:0]    pwdata,
    output logic [bpp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input words
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_source_pixel,
    // output words
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_out_alpha,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue
);

    localparam int unsigned NSTG = 10;
    localparam int unsigned LAST = NSTG - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0]       r_mask_red, r_mask_green, r_mask_blue, r_mask_alpha;
    bpp_pkg::t_reg_idx reg_idx;

    assign reg_idx = bpp_pkg::t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_red   <= bpp_pkg::RED_MASK_RST;
            r_mask_green <= bpp_pkg::GREEN_MASK_RST;
            r_mask_blue  <= bpp_pkg::BLUE_MASK_RST;
            r_mask_alpha <= bpp_pkg::ALPHA_MASK_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                bpp_pkg::REG_RED_MASK:   r_mask_red   <= pwdata;
                bpp_pkg::REG_GREEN_MASK: r_mask_green <= pwdata;
                bpp_pkg::REG_BLUE_MASK:  r_mask_blue  <= pwdata;
                bpp_pkg::REG_ALPHA_MASK: r_mask_alpha <= pwdata;
                default:                 r_mask_alpha <= r_mask_alpha;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bpp_pkg::REG_RED_MASK:   prdata = r_mask_red;
            bpp_pkg::REG_GREEN_MASK: prdata = r_mask_green;
            bpp_pkg::REG_BLUE_MASK:  prdata = r_mask_blue;
            bpp_pkg::REG_ALPHA_MASK: prdata = r_mask_alpha;
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[LAST] = !r_vld[LAST] || i_ready;
        for (int s = LAST - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[LAST];

    // ------------------------------------------------------------------
    // datapath registers; channel index 0..2 = red, green, blue, 3 = alpha
    // ------------------------------------------------------------------
    logic [31:0]                r_pix;
    logic [31:0]                r_mw   [4];
    logic [4:0]                 r_sh   [4];
    logic [7:0]                 r_ch   [4];
    logic [15:0]                r_csq  [3];
    logic [23:0]                r_cca  [3];
    logic [bpp_pkg::Q_W-1:0]    r_q    [3];
    bpp_pkg::t_sqrt             r_sq6  [3];
    bpp_pkg::t_sqrt             r_sq7  [3];
    bpp_pkg::t_sqrt             r_sq8  [3];
    logic [7:0]                 r_k    [3];
    logic [7:0]                 r_a3, r_a4, r_a5, r_a6, r_a7, r_a8, r_a9;

    logic [31:0]                n_mask [4];
    logic [7:0]                 n_ch   [4];
    logic [bpp_pkg::X_W-1:0]    n_x    [3];
    logic [bpp_pkg::X_W+bpp_pkg::RECIP_W-1:0] n_prod [3];
    bpp_pkg::t_sqrt             n_sq6  [3];
    bpp_pkg::t_sqrt             n_sq7  [3];
    bpp_pkg::t_sqrt             n_sq8  [3];
    logic [bpp_pkg::ROOT_W:0]   n_rnd  [3];

    always_comb begin
        n_mask[0] = r_mask_red;
        n_mask[1] = r_mask_green;
        n_mask[2] = r_mask_blue;
        n_mask[3] = (r_mask_alpha == '0) ? ~(r_mask_red | r_mask_green | r_mask_blue)
                                         : r_mask_alpha;
    end

    // shift and clamp to 255
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic [31:0] v;
            v       = r_mw[c] >> r_sh[c];
            n_ch[c] = (|v[31:8]) ? 8'hFF : v[7:0];
        end
    end

    // x = 4*c*c*a, then floor(x/255), then square root, three bits a stage
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            bpp_pkg::t_sqrt st;
            n_x[c]    = {r_cca[c], 2'b00};
            n_prod[c] = n_x[c] * bpp_pkg::RECIP_255;

            st = '{q: r_q[c], rem: '0, root: '0};
            for (int j = 0; j < 3; j++) begin
                st = bpp_pkg::sqrt_step(st, 8 - j);
            end
            n_sq6[c] = st;

            st = r_sq6[c];
            for (int j = 0; j < 3; j++) begin
                st = bpp_pkg::sqrt_step(st, 5 - j);
            end
            n_sq7[c] = st;

            st = r_sq7[c];
            for (int j = 0; j < 3; j++) begin
                st = bpp_pkg::sqrt_step(st, 2 - j);
            end
            n_sq8[c] = st;

            // k = (isqrt(q) + 1) / 2
            n_rnd[c] = {1'b0, r_sq8[c].root} + 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_pix <= i_source_pixel;
        end
        if (adv[1]) begin
            for (int c = 0; c < 4; c++) begin
                r_mw[c] <= r_pix & n_mask[c];
                r_sh[c] <= bpp_pkg::low_bit_index(n_mask[c]);
            end
        end
        if (adv[2]) begin
            r_ch <= n_ch;
        end
        if (adv[3]) begin
            for (int c = 0; c < 3; c++) begin
                r_csq[c] <= r_ch[c] * r_ch[c];
            end
            r_a3 <= r_ch[3];
        end
        if (adv[4]) begin
            for (int c = 0; c < 3; c++) begin
                r_cca[c] <= r_csq[c] * r_a3;
            end
            r_a4 <= r_a3;
        end
        if (adv[5]) begin
            for (int c = 0; c < 3; c++) begin
                r_q[c] <= n_prod[c][bpp_pkg::RECIP_SHIFT +: bpp_pkg::Q_W];
            end
            r_a5 <= r_a4;
        end
        if (adv[6]) begin
            r_sq6 <= n_sq6;
            r_a6  <= r_a5;
        end
        if (adv[7]) begin
            r_sq7 <= n_sq7;
            r_a7  <= r_a6;
        end
        if (adv[8]) begin
            r_sq8 <= n_sq8;
            r_a8  <= r_a7;
        end
        if (adv[9]) begin
            for (int c = 0; c < 3; c++) begin
                r_k[c] <= n_rnd[c][8:1];
            end
            r_a9 <= r_a8;
        end
    end

    assign o_out_alpha = r_a9;
    assign o_out_red   = r_k[0];
    assign o_out_green = r_k[1];
    assign o_out_blue  = r_k[2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // zero alpha forces every colour to zero
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_alpha == 8'd0) |->
            (o_out_red == 8'd0 && o_out_green == 8'd0 && o_out_blue == 8'd0))
        else $error("nonzero colour with zero alpha");

    // input may only back up when the pipe is full and the receiver stalls
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && (&r_vld)))
        else $error("input stalled without a full, stalled pipe");

    // square root remainder stays within 2*root on the last sqrt stage
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8] |->
            ({1'b0, r_sq8[0].rem} <= {r_sq8[0].root, 1'b0} &&
             {1'b0, r_sq8[1].rem} <= {r_sq8[1].root, 1'b0} &&
             {1'b0, r_sq8[2].rem} <= {r_sq8[2].root, 1'b0}))
        else $error("square root remainder out of range");

endmodule
